/* src/ogt_pkg.sv */
// ----------------------------------------------------------------------------
// Occupancy grid tracker package
// Shared constants, codes and widths of the occupancy grid tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ogt_pkg;

  localparam int unsigned GRID_W_DEF     = 64;
  localparam int unsigned GRID_H_DEF     = 64;

  localparam int unsigned PROB_FRAC_BITS = 16;
  localparam int unsigned PROB_W         = PROB_FRAC_BITS + 1;
  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;

  localparam int unsigned COORD_W        = 6;
  localparam int unsigned RATE_W         = 14;
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(8323);

  localparam int unsigned Q16_SHIFT      = 16;
  localparam logic [15:0] DIAG_SCALE     = 16'd46341;

  localparam int unsigned DIV_NW         = PROB_W + PROB_FRAC_BITS;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] MODE_UNKNOWN   = 2'd0;
  localparam logic [1:0] MODE_IMMEDIATE = 2'd1;
  localparam logic [1:0] MODE_HIDDEN    = 2'd2;

  localparam logic [2:0] REG_RATE_ADDR = 3'd0;

endpackage

`default_nettype wire

/* src/ogt_div.sv */
// ----------------------------------------------------------------------------
// Occupancy grid tracker divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ogt_div #(
  parameter int unsigned NW = ogt_pkg::DIV_NW,
  parameter int unsigned DW = 29
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic [NW-1:0]      quotient_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] dvd_q, dvd_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dsr_q, dsr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[NW-1]};
    diff   = trial - {1'b0, dsr_q};
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[DW-1:0];
        dvd_d = {dvd_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        dvd_d = {dvd_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

`default_nettype wire

/* src/occupancy_grid_tracker.sv */
// ----------------------------------------------------------------------------
// Occupancy grid tracker
// Probability grid of a target position with renormalization and diffusion.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  s_axis    in         tvalid/tready         tuser: op, tdata: cell fields
//  m_axis    out        tvalid/tready         tdata: result fields
//  apb       in         psel/penable/pready   diffusion_rate at address 0
//
// A write or an idle tick is answered from idle and a read through the read
// state. A tick scans the grid with one memory port per array: an immediate
// tick clears every cell but the new estimate, a hidden tick clears visible
// cells and sums and renormalizes the others; both then clear the buffer,
// diffuse and copy. After reset a clearing pass over every cell runs before
// the first transaction is taken. A stalled result holds the block in idle.
`default_nettype none

module occupancy_grid_tracker #(
  parameter int unsigned GRID_W = ogt_pkg::GRID_W_DEF,
  parameter int unsigned GRID_H = ogt_pkg::GRID_H_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // cell_x, cell_y, traversable, visible, immediate, zero fill
  input  wire logic [15:0] s_axis_tdata_i,
  // operation
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // cell_prob, tracking_state, estimate_x, estimate_y, mass_lost
  output logic [31:0]      m_axis_tdata_o,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);

  localparam int unsigned XW    = $clog2(GRID_W);
  localparam int unsigned YW    = $clog2(GRID_H);
  localparam int unsigned CELLS = GRID_W * GRID_H;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned PW    = ogt_pkg::PROB_W;
  localparam int unsigned BW    = PW + 1;
  localparam int unsigned SW    = AW + PW;
  localparam int unsigned NW    = ogt_pkg::DIV_NW;
  localparam int unsigned CW    = ogt_pkg::COORD_W;
  localparam int unsigned RW    = ogt_pkg::RATE_W;
  localparam logic [AW-1:0] W_A    = AW'(GRID_W);
  localparam logic [XW-1:0] X_LAST = XW'(GRID_W - 1);
  localparam logic [YW-1:0] Y_LAST = YW'(GRID_H - 1);

  typedef enum logic [18:0] {
    S_IDLE    = 19'h00001,
    S_READ    = 19'h00002,
    S_CLEAR   = 19'h00004,
    S_SUM_RD  = 19'h00008,
    S_SUM_UP  = 19'h00010,
    S_DIV_RD  = 19'h00020,
    S_DIV_ST  = 19'h00040,
    S_DIV_WT  = 19'h00080,
    S_BCLR    = 19'h00100,
    S_DF_RD   = 19'h00200,
    S_DF_MUL  = 19'h00400,
    S_DF_DIAG = 19'h00800,
    S_DF_NB   = 19'h01000,
    S_DF_UPD  = 19'h02000,
    S_SELF_RD = 19'h04000,
    S_SELF_WR = 19'h08000,
    S_CP_RD   = 19'h10000,
    S_CP_WR   = 19'h20000,
    S_DONE    = 19'h40000
  } state_e;

  state_e state_q, state_d;

  logic [PW-1:0] prob_mem [CELLS];
  logic [1:0]    flag_mem [CELLS];
  logic [BW-1:0] buf_mem  [CELLS];

  logic          prob_we, flag_we, buf_we;
  logic [AW-1:0] prob_waddr, flag_waddr, buf_waddr;
  logic [AW-1:0] prob_raddr, flag_raddr, buf_raddr;
  logic [PW-1:0] prob_wdata, prob_rd_q;
  logic [1:0]    flag_wdata, flag_rd_q;
  logic [BW-1:0] buf_wdata, buf_rd_q;

  logic [RW-1:0] rate_q, rate_d;
  logic [1:0]    mode_q, mode_d;
  logic [XW-1:0] est_x_q, est_x_d, cx_q, cx_d, best_x_q, best_x_d;
  logic [YW-1:0] est_y_q, est_y_d, cy_q, cy_d, best_y_q, best_y_d;
  logic [1:0]    ndx_q, ndx_d, ndy_q, ndy_d;
  logic          clr_all_q, clr_all_d, lost_q, lost_d, rd_ok_q, rd_ok_d;
  logic          best_v_q, best_v_d;
  logic [PW-1:0] best_q, best_d, share_q, share_d, diag_q, diag_d;
  logic [PW-1:0] left_q, left_d;
  logic [SW-1:0] sum_q, sum_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_data_q, out_data_d;

  logic [1:0]    in_op;
  logic [CW-1:0] in_x, in_y;
  logic          in_trav, in_vis, in_imm, in_grid, in_acc;
  logic [XW-1:0] in_cx, clamp_x;
  logic [YW-1:0] in_cy, clamp_y;
  logic [AW-1:0] in_addr, cur_addr, nb_addr;
  logic [XW-1:0] nx;
  logic [YW-1:0] ny;
  logic          nb_ok, nb_last, nb_diag, scan_last;
  logic [PW-1:0] nb_d;
  logic [RW+PW-1:0] mul_a;
  logic [PW+15:0]   mul_b;
  logic [PW-1:0]    q_sat;
  logic          div_start, div_done;
  logic [NW-1:0] div_quo;
  logic          cfg_we;

  assign in_op   = s_axis_tuser_i;
  assign in_x    = s_axis_tdata_i[5:0];
  assign in_y    = s_axis_tdata_i[11:6];
  assign in_trav = s_axis_tdata_i[12];
  assign in_vis  = s_axis_tdata_i[13];
  assign in_imm  = s_axis_tdata_i[14];
  assign in_grid = (32'(in_x) < GRID_W) && (32'(in_y) < GRID_H);
  assign in_cx   = XW'(in_x);
  assign in_cy   = YW'(in_y);
  assign clamp_x = (32'(in_x) < GRID_W) ? XW'(in_x) : X_LAST;
  assign clamp_y = (32'(in_y) < GRID_H) ? YW'(in_y) : Y_LAST;
  assign in_addr = AW'(in_cy) * W_A + AW'(in_cx);
  assign cur_addr = AW'(cy_q) * W_A + AW'(cx_q);

  assign nx      = cx_q + XW'(ndx_q) - XW'(1);
  assign ny      = cy_q + YW'(ndy_q) - YW'(1);
  assign nb_addr = AW'(ny) * W_A + AW'(nx);
  assign nb_ok   = !(ndx_q == 2'd1 && ndy_q == 2'd1) &&
                   !(ndx_q == 2'd0 && cx_q == '0) && !(ndx_q == 2'd2 && cx_q == X_LAST) &&
                   !(ndy_q == 2'd0 && cy_q == '0) && !(ndy_q == 2'd2 && cy_q == Y_LAST);
  assign nb_last = (ndx_q == 2'd2) && (ndy_q == 2'd2);
  assign nb_diag = (ndx_q != 2'd1) && (ndy_q != 2'd1);
  assign nb_d    = nb_diag ? ((diag_q > left_q) ? left_q : diag_q)
                           : ((share_q > left_q) ? left_q : share_q);
  assign scan_last = (cx_q == X_LAST) && (cy_q == Y_LAST);

  assign mul_a = RW'(rate_q) * PW'(prob_rd_q);
  assign mul_b = share_q * ogt_pkg::DIAG_SCALE;
  assign q_sat = (div_quo > NW'(ogt_pkg::PROB_ONE)) ? ogt_pkg::PROB_ONE : div_quo[PW-1:0];

  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_we = psel_i && penable_i && pwrite_i && pready_o && (paddr_i[2] == 1'b0);

  ogt_div #(
    .NW (NW),
    .DW (SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({prob_rd_q, ogt_pkg::PROB_FRAC_BITS'(0)}),
    .divisor_i  (sum_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    rate_d      = cfg_we ? pwdata_i[RW-1:0] : rate_q;
    mode_d      = mode_q;
    est_x_d     = est_x_q;
    est_y_d     = est_y_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    ndx_d       = ndx_q;
    ndy_d       = ndy_q;
    best_x_d    = best_x_q;
    best_y_d    = best_y_q;
    best_v_d    = best_v_q;
    best_d      = best_q;
    share_d     = share_q;
    diag_d      = diag_q;
    left_d      = left_q;
    sum_d       = sum_q;
    clr_all_d   = clr_all_q;
    lost_d      = lost_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    prob_we     = 1'b0;
    prob_waddr  = cur_addr;
    prob_wdata  = '0;
    prob_raddr  = cur_addr;
    flag_we     = 1'b0;
    flag_waddr  = cur_addr;
    flag_wdata  = '0;
    flag_raddr  = cur_addr;
    buf_we      = 1'b0;
    buf_waddr   = cur_addr;
    buf_wdata   = '0;
    buf_raddr   = cur_addr;
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        prob_raddr = in_addr;
        if (in_acc) begin
          lost_d = 1'b0;
          cx_d   = '0;
          cy_d   = '0;
          if (in_op == ogt_pkg::OP_READ) begin
            rd_ok_d = in_grid;
            state_d = S_READ;
          end else if (in_op == ogt_pkg::OP_TICK && in_imm) begin
            mode_d    = ogt_pkg::MODE_IMMEDIATE;
            est_x_d   = clamp_x;
            est_y_d   = clamp_y;
            clr_all_d = 1'b0;
            state_d   = S_CLEAR;
          end else if (in_op == ogt_pkg::OP_TICK && mode_q != ogt_pkg::MODE_UNKNOWN) begin
            mode_d  = ogt_pkg::MODE_HIDDEN;
            sum_d   = '0;
            state_d = S_SUM_RD;
          end else begin
            if (in_op == ogt_pkg::OP_WRITE && in_grid) begin
              flag_we    = 1'b1;
              flag_waddr = in_addr;
              flag_wdata = {in_trav, in_vis};
            end
            out_valid_d = 1'b1;
            out_data_d  = {1'b0, CW'(est_y_q), CW'(est_x_q), mode_q, PW'(0)};
          end
        end
      end
      S_READ: begin
        out_valid_d = 1'b1;
        out_data_d  = {1'b0, CW'(est_y_q), CW'(est_x_q), mode_q,
                       rd_ok_q ? prob_rd_q : PW'(0)};
        state_d     = S_IDLE;
      end
      S_CLEAR: begin
        prob_we    = 1'b1;
        prob_wdata = (!clr_all_q && cx_q == est_x_q && cy_q == est_y_q) ?
                     ogt_pkg::PROB_ONE : PW'(0);
        flag_we    = clr_all_q;
        if (scan_last) begin
          cx_d      = '0;
          cy_d      = '0;
          clr_all_d = 1'b0;
          state_d   = clr_all_q ? S_IDLE : S_BCLR;
        end
      end
      S_SUM_RD: begin
        state_d = S_SUM_UP;
      end
      S_SUM_UP: begin
        if (flag_rd_q[0]) begin
          prob_we = 1'b1;
        end else begin
          sum_d = sum_q + SW'(prob_rd_q);
        end
        state_d = S_SUM_RD;
        if (scan_last) begin
          cx_d     = '0;
          cy_d     = '0;
          best_v_d = 1'b0;
          if (sum_d == '0) begin
            lost_d  = 1'b1;
            state_d = S_BCLR;
          end else begin
            state_d = S_DIV_RD;
          end
        end
      end
      S_DIV_RD: begin
        state_d = S_DIV_ST;
      end
      S_DIV_ST: begin
        if (flag_rd_q[0]) begin
          state_d = S_DIV_RD;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV_WT;
        end
      end
      S_DIV_WT: begin
        if (div_done) begin
          prob_we    = 1'b1;
          prob_wdata = q_sat;
          if (!best_v_q || q_sat > best_q) begin
            best_v_d = 1'b1;
            best_d   = q_sat;
            best_x_d = cx_q;
            best_y_d = cy_q;
          end
          state_d = S_DIV_RD;
        end
      end
      S_BCLR: begin
        buf_we = 1'b1;
        if (scan_last) begin
          cx_d    = '0;
          cy_d    = '0;
          state_d = S_DF_RD;
        end
      end
      S_DF_RD: begin
        state_d = S_DF_MUL;
      end
      S_DF_MUL: begin
        share_d = PW'(mul_a >> ogt_pkg::Q16_SHIFT);
        left_d  = prob_rd_q;
        ndx_d   = '0;
        ndy_d   = '0;
        state_d = S_DF_DIAG;
      end
      S_DF_DIAG: begin
        diag_d  = PW'(mul_b >> ogt_pkg::Q16_SHIFT);
        state_d = S_DF_NB;
      end
      S_DF_NB, S_DF_UPD: begin
        flag_raddr = nb_addr;
        buf_raddr  = nb_addr;
        if (state_q == S_DF_NB && nb_ok) begin
          state_d = S_DF_UPD;
        end else begin
          if (state_q == S_DF_UPD && flag_rd_q[1]) begin
            buf_we    = 1'b1;
            buf_waddr = nb_addr;
            buf_wdata = buf_rd_q + BW'(nb_d);
            left_d    = left_q - nb_d;
          end
          if (nb_last) begin
            state_d = S_SELF_RD;
          end else begin
            state_d = S_DF_NB;
            if (ndy_q == 2'd2) begin
              ndx_d = ndx_q + 2'd1;
              ndy_d = '0;
            end else begin
              ndy_d = ndy_q + 2'd1;
            end
          end
        end
      end
      S_SELF_RD: begin
        state_d = S_SELF_WR;
      end
      S_SELF_WR: begin
        buf_we    = 1'b1;
        buf_wdata = buf_rd_q + BW'(left_q);
        state_d   = S_DF_RD;
        if (scan_last) begin
          cx_d    = '0;
          cy_d    = '0;
          state_d = S_CP_RD;
        end
      end
      S_CP_RD: begin
        state_d = S_CP_WR;
      end
      S_CP_WR: begin
        prob_we    = 1'b1;
        prob_wdata = (buf_rd_q > BW'(ogt_pkg::PROB_ONE)) ? ogt_pkg::PROB_ONE
                                                         : buf_rd_q[PW-1:0];
        state_d    = scan_last ? S_DONE : S_CP_RD;
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        out_data_d  = {lost_q, CW'(est_y_q), CW'(est_x_q), mode_q, PW'(0)};
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if ((state_q == S_CLEAR && !scan_last) || (state_q == S_SUM_UP && !scan_last) ||
        (state_q == S_DIV_ST && flag_rd_q[0]) || (state_q == S_DIV_WT && div_done) ||
        (state_q == S_BCLR && !scan_last) || (state_q == S_SELF_WR && !scan_last) ||
        (state_q == S_CP_WR && !scan_last)) begin
      if (state_q == (S_DIV_ST) || state_q == S_DIV_WT) begin
        if (scan_last) begin
          cx_d    = '0;
          cy_d    = '0;
          state_d = S_BCLR;
          if (best_v_d) begin
            est_x_d = best_x_d;
            est_y_d = best_y_d;
          end
        end else if (cx_q == X_LAST) begin
          cx_d = '0;
          cy_d = cy_q + YW'(1);
        end else begin
          cx_d = cx_q + XW'(1);
        end
      end else if (cx_q == X_LAST) begin
        cx_d = '0;
        cy_d = cy_q + YW'(1);
      end else begin
        cx_d = cx_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rate_q      <= ogt_pkg::RATE_RESET;
      mode_q      <= ogt_pkg::MODE_UNKNOWN;
      est_x_q     <= '0;
      est_y_q     <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      ndx_q       <= '0;
      ndy_q       <= '0;
      clr_all_q   <= 1'b1;
      lost_q      <= 1'b0;
      rd_ok_q     <= 1'b0;
      best_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rate_q      <= rate_d;
      mode_q      <= mode_d;
      est_x_q     <= est_x_d;
      est_y_q     <= est_y_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      ndx_q       <= ndx_d;
      ndy_q       <= ndy_d;
      clr_all_q   <= clr_all_d;
      lost_q      <= lost_d;
      rd_ok_q     <= rd_ok_d;
      best_v_q    <= best_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_x_q   <= best_x_d;
    best_y_q   <= best_y_d;
    share_q    <= share_d;
    diag_q     <= diag_d;
    left_q     <= left_d;
    sum_q      <= sum_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (prob_we) begin
      prob_mem[prob_waddr] <= prob_wdata;
    end
    prob_rd_q <= prob_mem[prob_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    flag_rd_q <= flag_mem[flag_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
    buf_rd_q <= buf_mem[buf_raddr];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign pready_o        = 1'b1;
  assign prdata_o        = (paddr_i == ogt_pkg::REG_RATE_ADDR) ? 32'(rate_q) : 32'd0;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> state_q == S_IDLE)
    else $error("input taken outside idle");

  a_lost_hidden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[31]) |->
      m_axis_tdata_o[18:17] == ogt_pkg::MODE_HIDDEN)
    else $error("mass lost reported outside hidden mode");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV_WT)
    else $error("divider finished while not awaited");

endmodule

`default_nettype wire
